// File: src/pcr_pkg.sv
package pcr_pkg;

   localparam int unsigned DepthDefault = 16384;
   localparam int unsigned CapWidth = 15;
   localparam logic [CapWidth-1:0] CapReset = 15'd16384;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // back stage sequence: execute, memory read, output
   typedef enum logic [1:0] {
      ST_EXEC,
      ST_READ,
      ST_OUT
   } st_type;

   // one classified command from front to back
   typedef struct packed {
      op_type       op;
      logic [15:0]  pcm;
      logic [13:0]  index;
   } cmd_type;

   // Float32 to int16: clamp, scale by 32767 or 32768, round half even.
   // 32768 scaling is exact. The 32767 product is first rounded to float
   // precision (24 significant bits, ties to even), then to integer, so a
   // product just below .5 that rounds up to .5 as a float takes the tie rule.
   function automatic logic [15:0] to_pcm16(input logic [31:0] bits);
      logic        sgn;
      logic [7:0]  ex;
      logic [23:0] man;
      logic [47:0] prod;
      logic [47:0] fix;
      logic [16:0] ip;
      logic        half, sticky, up, rnd;
      logic [16:0] mag;
      int          sh;
      sgn  = bits[31];
      ex   = bits[30:23];
      man  = {1'b1, bits[22:0]};
      to_pcm16 = 16'd0;
      if (ex == 8'hFF) begin
         to_pcm16 = 16'd0;
      end else if (ex >= 8'd127) begin
         to_pcm16 = sgn ? 16'h8000 : 16'h7FFF;
      end else if (ex < 8'd110) begin
         to_pcm16 = 16'd0;
      end else begin
         if (sgn) prod = {9'd0, man, 15'd0};
         else     prod = {9'd0, man, 15'd0} - {24'd0, man};
         // positive product has its top bit at 38 or 37; keep 24 bits
         if (!sgn) begin
            if (prod[38]) begin
               rnd  = prod[14] & ((|prod[13:0]) | prod[15]);
               prod = {prod[47:15] + 33'(rnd), 15'd0};
            end else begin
               rnd  = prod[13] & ((|prod[12:0]) | prod[14]);
               prod = {prod[47:14] + 34'(rnd), 14'd0};
            end
         end
         // value = prod * 2^(ex-127-23); integer point at bit (150-ex)
         sh     = 150 - int'(ex);
         fix    = prod >> sh;
         ip     = fix[16:0];
         half   = prod[sh-1];
         sticky = |(prod & ((48'd1 << (sh-1)) - 48'd1));
         up     = half & (sticky | ip[0]);
         mag    = ip + {16'd0, up};
         to_pcm16 = sgn ? 16'(~mag + 17'd1) : mag[15:0];
      end
   endfunction

endpackage

// File: src/pcm16_capture_ring.sv
// Float32 audio capture ring with int16 PCM storage.
// req: tdata {read_index, sample_bits, opcode}; opcode 0 push, 1 read, 2 clear.
// rsp: one transfer per request: pcm_value, read_valid, written and dropped
//   totals, held_count.
// csr: write csr_we with csr_wdata to set the capacity; also clears totals.
// Front stage converts the sample and registers the command; the back stage
// executes it. A read goes through a memory read state before the result
// transfer; the result waits while the receiver holds rsp_tready low.
// The front takes the next request while the back works on the previous one.
// The back stage takes no new item until the previous result has transferred,
// set by the back stage sequence (execute, read, output) that holds one item at a time.
// Reset: capacity 16384, totals and write slot zero; memory undefined.
// When rsp_tready is low, the result is held and the front stalls once full.
module pcm16_capture_ring #(
   parameter int unsigned DEPTH = pcr_pkg::DepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // opcode[1:0], sample_bits[33:2], read_index[47:34]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // pcm_value[15:0], read_valid[16],
                                     // written_count[80:17], dropped_count[144:81],
                                     // held_count[159:145]
   input  logic         csr_we,
   input  logic [14:0]  csr_wdata
);

   logic             q_valid, q_ready;
   pcr_pkg::cmd_type q_cmd;

   pcr_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_ready, .q_cmd
   );

   pcr_back #(.DEPTH(DEPTH)) u_back (
      .clock, .reset, .csr_we, .csr_wdata, .q_valid, .q_ready, .q_cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

// File: src/pcr_front.sv
module pcr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,
   output logic               q_valid,
   input  logic               q_ready,
   output pcr_pkg::cmd_type   q_cmd
);

   pcr_pkg::cmd_type cmd_ff, cmd_in;
   logic             valid_ff;

   // decode and convert
   always_comb begin
      cmd_in.op    = pcr_pkg::op_type'(req_tdata[1:0]);
      cmd_in.index = req_tdata[47:34];
      cmd_in.pcm   = (req_tdata[1:0] == pcr_pkg::OP_PUSH) ?
                     pcr_pkg::to_pcm16(req_tdata[33:2]) : 16'd0;
   end

   assign req_tready = !valid_ff || q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_cmd   = cmd_ff;

endmodule

// File: src/pcr_back.sv
module pcr_back #(
   parameter int unsigned DEPTH = pcr_pkg::DepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [14:0]        csr_wdata,
   input  logic               q_valid,
   output logic               q_ready,
   input  pcr_pkg::cmd_type   q_cmd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [159:0]       rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [15:0]     mem [DEPTH];
   logic [15:0]     rd_data_ff;
   pcr_pkg::st_type st_ff, st_in;
   logic [14:0]     cap_ff;
   logic [AW-1:0]   slot_ff;
   logic [63:0]     wr_ff, dr_ff;
   logic [15:0]     pcm_ff;
   logic            valid_ff;
   logic [CW-1:0]   cap_e, held;
   logic [CW:0]     start, addr_s;
   logic [AW-1:0]   addr, slot_eff;
   logic            do_push, do_read, full;

   // effective capacity and window
   always_comb begin
      cap_e = (32'(cap_ff) > DEPTH) ? CW'(DEPTH) : CW'(cap_ff);
      full  = wr_ff >= 64'(cap_e);
      held  = full ? cap_e : CW'(wr_ff);
      slot_eff = (CW'(slot_ff) < cap_e) ? slot_ff : '0;
      start = (CW+1)'(slot_eff) + (CW+1)'(cap_e) - (CW+1)'(held);
      if (start >= (CW+1)'(cap_e)) start = start - (CW+1)'(cap_e);
      addr_s = start + (CW+1)'(q_cmd.index);
      if (addr_s >= (CW+1)'(cap_e)) addr_s = addr_s - (CW+1)'(cap_e);
      addr = addr_s[AW-1:0];
   end

   assign q_ready = (st_ff == pcr_pkg::ST_EXEC);
   assign do_push = q_valid && q_ready && q_cmd.op == pcr_pkg::OP_PUSH && cap_e != '0;
   assign do_read = q_valid && q_ready && q_cmd.op == pcr_pkg::OP_READ &&
                    (CW+1)'(q_cmd.index) < (CW+1)'(held);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         pcr_pkg::ST_EXEC: if (q_valid) st_in = do_read ? pcr_pkg::ST_READ : pcr_pkg::ST_OUT;
         pcr_pkg::ST_READ: st_in = pcr_pkg::ST_OUT;
         pcr_pkg::ST_OUT:  if (rsp_tready) st_in = pcr_pkg::ST_EXEC;
         default: st_in = pcr_pkg::ST_EXEC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= pcr_pkg::ST_EXEC;
      end else begin
         st_ff <= st_in;
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (do_push) mem[slot_eff] <= q_cmd.pcm;
      rd_data_ff <= mem[addr];
   end

   // counters and result
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= pcr_pkg::CapReset;
         slot_ff <= '0;
         wr_ff <= '0;
         dr_ff <= '0;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
         slot_ff <= '0;
         wr_ff <= '0;
         dr_ff <= '0;
      end else if (q_valid && q_ready) begin
         if (q_cmd.op == pcr_pkg::OP_CLEAR) begin
            slot_ff <= '0;
            wr_ff <= '0;
            dr_ff <= '0;
         end else if (do_push) begin
            slot_ff <= ((CW'(slot_eff) + CW'(1)) == cap_e) ? '0 : slot_eff + AW'(1);
            wr_ff <= wr_ff + 64'd1;
            if (full) dr_ff <= dr_ff + 64'd1;
         end
      end
      if (q_valid && q_ready) begin
         pcm_ff <= (q_cmd.op == pcr_pkg::OP_PUSH) ? q_cmd.pcm : 16'd0;
         valid_ff <= do_read;
      end else if (st_ff == pcr_pkg::ST_READ) begin
         pcm_ff <= rd_data_ff;
      end
   end

   assign rsp_tvalid = (st_ff == pcr_pkg::ST_OUT);
   assign rsp_tdata = {15'(held), dr_ff, wr_ff, valid_ff, pcm_ff};

endmodule
